[src/vsp_pkg.sv]
// version string packer: shared types, constants and a helper function
// no dependencies; imported by every module of the packer
`default_nettype none

package vsp_pkg;

    // fixed widths of the item fields
    localparam int CHAR_W = 16;
    localparam int WORD_W = 32;

    // default parameter values
    localparam int CHAR_BITS_DEFAULT   = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // tag base bytes: tag shift plus 128
    localparam logic [7:0] TAG_A     = 8'h20;
    localparam logic [7:0] TAG_B     = 8'h40;
    localparam logic [7:0] TAG_R     = 8'h60;
    localparam logic [7:0] TAG_P     = 8'hA0;
    localparam logic [7:0] TAG_OTHER = 8'h00;
    localparam logic [7:0] TAG_DIGIT = 8'h80;

    // filler byte for an absent component
    localparam logic [7:0] ABSENT_BYTE = 8'h80;

    // character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;
    localparam logic [CHAR_W-1:0] CH_DASH  = 16'h002D;
    localparam logic [CHAR_W-1:0] CH_UNDER = 16'h005F;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 16'h002B;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_LC_B  = 16'h0062;
    localparam logic [CHAR_W-1:0] CH_LC_R  = 16'h0072;
    localparam logic [CHAR_W-1:0] CH_UC_R  = 16'h0052;
    localparam logic [CHAR_W-1:0] CH_LC_P  = 16'h0070;

    // number of components in the packed word
    localparam int NUM_COMP = 4;

    // input transfer payload
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              cmd;
    } vsp_in_t;

    // output transfer payload
    typedef struct packed {
        logic [WORD_W-1:0]        version_word;
        logic signed [WORD_W-1:0] difference;
        logic                     compare_valid;
    } vsp_out_t;

    // classified character, as queued between front and back
    typedef struct packed {
        logic       has_char;
        logic       is_end;
        logic       is_digit;
        logic       is_sep;
        logic [3:0] digit;
        logic [7:0] tag_base;
        logic       cmd;
    } vsp_item_t;

    // parser phase, one-hot
    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_SKIP   = 5'b00010,
        PH_DIGITS = 5'b00100,
        PH_SEPS   = 5'b01000,
        PH_DONE   = 5'b10000
    } vsp_phase_t;

    // or a component byte (up to nine bits) into its slot of the word
    function automatic logic [WORD_W-1:0] vsp_merge(
        input logic [WORD_W-1:0] acc,
        input logic [1:0]        idx,
        input logic [8:0]        comp_byte
    );
        logic [4:0] sh;
        sh = 5'd24 - {idx, 3'b000};
        return acc | (WORD_W'(comp_byte) << sh);
    endfunction

endpackage

`default_nettype wire

[src/vsp_front.sv]
// version string packer front end: input handshake and character classification
// depends on vsp_pkg
`default_nettype none

module vsp_front #(
    parameter int CHAR_BITS = vsp_pkg::CHAR_BITS_DEFAULT
) (
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire vsp_pkg::vsp_in_t in_data,
    input  wire logic            queue_full,
    output logic                 push,
    output vsp_pkg::vsp_item_t   item
);
    import vsp_pkg::*;

    localparam int USE_BITS = (CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W;

    logic [CHAR_W-1:0] c;
    logic              digit_c;

    // keep only the character bits in use
    always_comb
    begin
        for (int i = 0; i < CHAR_W; i++)
        begin
            c[i] = (i < USE_BITS) ? in_data.char_code[i] : 1'b0;
        end
    end

    // accept whenever the queue has room
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    assign digit_c = (c >= CH_ZERO) && (c <= CH_NINE);

    // classification
    always_comb
    begin
        item.has_char = (c != '0);
        item.is_end   = (c == '0) || in_data.last;
        item.is_digit = digit_c;
        item.is_sep   = (c == CH_DOT) || (c == CH_DASH) || (c == CH_UNDER) || (c == CH_PLUS);
        item.digit    = c[3:0];
        item.cmd      = in_data.cmd;
        priority if (digit_c)
            item.tag_base = TAG_DIGIT;
        else if (c == CH_LC_A)
            item.tag_base = TAG_A;
        else if (c == CH_LC_B)
            item.tag_base = TAG_B;
        else if ((c == CH_LC_R) || (c == CH_UC_R))
            item.tag_base = TAG_R;
        else if (c == CH_LC_P)
            item.tag_base = TAG_P;
        else
            item.tag_base = TAG_OTHER;
    end

endmodule

`default_nettype wire

[src/vsp_queue.sv]
// version string packer: short queue of classified characters
// depends on vsp_pkg; depth must be a power of two, at least two
`default_nettype none

module vsp_queue #(
    parameter int DEPTH = vsp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire vsp_pkg::vsp_item_t push_item,
    input  wire logic               pop,
    output logic                    full,
    output logic                    not_empty,
    output vsp_pkg::vsp_item_t      head
);
    import vsp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    vsp_item_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    // checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

[src/vsp_back.sv]
// version string packer back end: component parser, word packing, compare and output register
// depends on vsp_pkg
`default_nettype none

module vsp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire vsp_pkg::vsp_item_t item,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output vsp_pkg::vsp_out_t       out_data
);
    import vsp_pkg::*;

    vsp_phase_t        phase_reg, phase_next;
    logic [2:0]        idx_reg, idx_next;
    logic [7:0]        base_reg, base_next;
    logic [6:0]        pv_reg, pv_next;
    logic [1:0]        dc_reg, dc_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] stored_reg, stored_next;
    logic              out_valid_reg, out_valid_next;
    vsp_out_t          out_reg, out_next;

    logic              out_free;
    logic              reopen;
    logic [WORD_W-1:0] word;

    // an ending item needs room in the output register
    assign out_free = !out_valid_reg || out_ready;
    assign pop      = item_valid && (!item.is_end || out_free);

    always_comb
    begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        pv_next        = pv_reg;
        dc_next        = dc_reg;
        acc_next       = acc_reg;
        stored_next    = stored_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        reopen         = 1'b0;
        word           = '0;

        if (pop)
        begin
            // step the parser with this character
            if (item.has_char)
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        reopen = 1'b1;
                    end
                    PH_SKIP:
                    begin
                        if (item.is_digit)
                        begin
                            pv_next    = 7'(item.digit);
                            dc_next    = 2'd1;
                            phase_next = PH_DIGITS;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (item.is_digit && (dc_reg != 2'd2))
                        begin
                            pv_next = 7'(pv_reg * 7'd10) + 7'(item.digit);
                            dc_next = 2'd2;
                        end
                        else if (item.is_sep)
                            phase_next = PH_SEPS;
                        else
                        begin
                            acc_next   = vsp_merge(acc_reg, idx_reg[1:0],
                                                   9'(base_reg) + 9'(pv_reg));
                            idx_next   = idx_reg + 3'd1;
                            phase_next = (idx_reg == 3'(NUM_COMP - 1)) ? PH_DONE : PH_START;
                            reopen     = (idx_reg != 3'(NUM_COMP - 1));
                        end
                    end
                    PH_SEPS:
                    begin
                        if (!item.is_sep)
                        begin
                            acc_next   = vsp_merge(acc_reg, idx_reg[1:0],
                                                   9'(base_reg) + 9'(pv_reg));
                            idx_next   = idx_reg + 3'd1;
                            phase_next = (idx_reg == 3'(NUM_COMP - 1)) ? PH_DONE : PH_START;
                            reopen     = (idx_reg != 3'(NUM_COMP - 1));
                        end
                    end
                    PH_DONE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase

                // open a new component on this character
                if (reopen)
                begin
                    base_next = item.tag_base;
                    if (item.is_digit)
                    begin
                        pv_next    = 7'(item.digit);
                        dc_next    = 2'd1;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        pv_next    = '0;
                        dc_next    = 2'd0;
                        phase_next = PH_SKIP;
                    end
                end
            end

            // end of string: close, fill absent components, emit
            if (item.is_end)
            begin
                if ((phase_next == PH_SKIP) || (phase_next == PH_DIGITS) ||
                    (phase_next == PH_SEPS))
                begin
                    acc_next = vsp_merge(acc_next, idx_next[1:0],
                                         9'(base_next) + 9'(pv_next));
                    idx_next = idx_next + 3'd1;
                end
                for (int i = 0; i < NUM_COMP; i++)
                begin
                    if (3'(i) >= idx_next)
                        acc_next = vsp_merge(acc_next, 2'(i), 9'(ABSENT_BYTE));
                end
                word = acc_next;

                out_valid_next       = 1'b1;
                out_next.version_word = word;
                if (item.cmd)
                begin
                    out_next.difference    = $signed(stored_reg - word);
                    out_next.compare_valid = 1'b1;
                end
                else
                begin
                    out_next.difference    = '0;
                    out_next.compare_valid = 1'b0;
                    stored_next            = word;
                end

                phase_next = PH_START;
                idx_next   = '0;
                base_next  = '0;
                pv_next    = '0;
                dc_next    = '0;
                acc_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            idx_reg       <= '0;
            base_reg      <= '0;
            pv_reg        <= '0;
            dc_reg        <= '0;
            acc_reg       <= '0;
            stored_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            base_reg      <= base_next;
            pv_reg        <= pv_next;
            dc_reg        <= dc_next;
            acc_reg       <= acc_next;
            stored_reg    <= stored_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // checks
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && item.is_end) |=> (phase_reg == PH_START) && (idx_reg == '0) && (acc_reg == '0))
        else $error("parser not cleared after string end");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg <= 3'(NUM_COMP)) && ((idx_reg == 3'(NUM_COMP)) == (phase_reg == PH_DONE)))
        else $error("component index out of step with phase");

    a_plain_store: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.compare_valid) |-> (out_reg.difference == '0))
        else $error("difference set on a store result");

endmodule

`default_nettype wire

[src/version_string_packer.sv]
// Version string packer: takes one character per transfer and returns the packed
// four-component version word and, for a string with cmd set, its difference from the
// word stored by the last string without cmd. One character is accepted every clock cycle
// while the queue is not full. A string's result passes through the classification queue
// entry and then the output register after the transfer that ends it (a terminator or last).
// While a result waits in the output register, characters that do not end a string keep
// draining; a string end waits in the queue, and once the short queue between the classifier
// and the parser is full the input stalls. No clearing pass after reset.
// depends on vsp_pkg, vsp_front, vsp_queue, vsp_back
`default_nettype none

module version_string_packer #(
    parameter int CHAR_BITS   = vsp_pkg::CHAR_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = vsp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire vsp_pkg::vsp_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output vsp_pkg::vsp_out_t     out_data
);
    import vsp_pkg::*;

    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_not_empty;
    vsp_item_t front_item;
    vsp_item_t head_item;

    // classify incoming characters
    vsp_front #(
        .CHAR_BITS (CHAR_BITS)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .item       (front_item)
    );

    // decoupling queue
    vsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_item)
    );

    // parse, pack and compare
    vsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_not_empty),
        .item       (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire
